// ===== hw/rtl/rts_pkg.sv =====
// Package for the radio tuning stepper: widths, reset values, codes and the
// command/status structs shared by controller and datapath. No dependencies.
package rts_pkg;

  localparam int unsigned FreqW    = 16;
  localparam int unsigned OffW     = 10;
  localparam int unsigned StepW    = 8;
  localparam int unsigned BfoW     = 10;
  localparam int unsigned RepW     = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned MaxRepeatsDef = 128;

  localparam logic [FreqW-1:0] BandMinRst = 16'd520;
  localparam logic [FreqW-1:0] BandMaxRst = 16'd1710;
  localparam logic [StepW-1:0] StepRst    = 8'd10;
  localparam logic [BfoW-1:0]  BfoRst     = 10'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BAND_MIN = 3'd0,
    CFG_BAND_MAX = 3'd1,
    CFG_STEP     = 3'd2,
    CFG_ORIGIN   = 3'd3,
    CFG_MODE     = 3'd4,
    CFG_BFO      = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_GRID  = 2'd1,
    MODE_SSB   = 2'd2,
    MODE_SPARE = 2'd3
  } tune_mode_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic start;     // latch request, snapshot old state
    logic load;      // apply a load request
    logic rem_init;  // begin a remainder computation
    logic rem_step;  // one restoring-subtract iteration
    logic edge_lo;   // capture first grid channel from remainder
    logic edge_hi;   // capture last grid channel from remainder
    logic rem_cur;   // remainder operand is the current frequency
    logic rem_lo;    // remainder operand is band_min
    logic step;      // apply one step (plain / sideband)
    logic grid_step; // apply one grid step using the remainder
  } rts_cmd_t;

  typedef struct packed {
    logic rem_done;
  } rts_sts_t;

endpackage

// ===== hw/rtl/radio_tuning_stepper.sv =====
// Top level of the radio tuning stepper: configuration registers, controller
// and datapath. Depends on rts_pkg, rts_ctrl and rts_datapath.
//
// Usage: one request enters on in_valid_i/in_ready_o; one result leaves on
// out_valid_o/out_ready_i. Configuration must be written through cfg_we_i,
// cfg_idx_i and cfg_data_i only while the block is idle; the block itself
// does not enforce it. Load and no-op requests go straight to the result.
// Plain and sideband steps apply one step per cycle per repeat; a grid
// step searches the low and high band edges, then runs one remainder per
// repeat in the bit-serial remainder unit (one quotient bit a cycle).
// One request is worked at a time; in_ready_o is high only when idle.
// Reset sets the registers to their defaults, the frequency to 520 kHz and
// the offset to zero. If the receiver stalls the result is held and no new
// request is taken until it is delivered.
module radio_tuning_stepper #(
  parameter int unsigned MaxRepeats = rts_pkg::MaxRepeatsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic [1:0]                   direction_i,
  input  logic [rts_pkg::RepW-1:0]     repeats_i,
  input  logic [rts_pkg::FreqW-1:0]    load_frequency_khz_i,
  input  logic [rts_pkg::OffW-1:0]     load_offset_hz_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rts_pkg::FreqW-1:0]    frequency_khz_o,
  output logic [rts_pkg::OffW-1:0]     offset_hz_o,
  output logic                         changed_o,
  input  logic                         cfg_we_i,
  input  logic [rts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rts_pkg::CfgDataW-1:0] cfg_data_i
);
  import rts_pkg::*;

  logic [FreqW-1:0] band_min_q, band_max_q, origin_q;
  logic [StepW-1:0] step_q;
  logic [1:0]       mode_q;
  logic [BfoW-1:0]  bfo_q;
  rts_cmd_t cmd;
  rts_sts_t sts;
  logic dir_neg;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_min_q <= BandMinRst;
      band_max_q <= BandMaxRst;
      step_q     <= StepRst;
      origin_q   <= '0;
      mode_q     <= MODE_PLAIN;
      bfo_q      <= BfoRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BAND_MIN: band_min_q <= cfg_data_i;
        CFG_BAND_MAX: band_max_q <= cfg_data_i;
        CFG_STEP:     step_q     <= cfg_data_i[StepW-1:0];
        CFG_ORIGIN:   origin_q   <= cfg_data_i;
        CFG_MODE:     mode_q     <= cfg_data_i[1:0];
        CFG_BFO:      bfo_q      <= cfg_data_i[BfoW-1:0];
        default: ;
      endcase
    end
  end

  rts_ctrl #(.MaxRepeats(MaxRepeats)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .req_type_i, .direction_i, .repeats_i,
    .mode_i(mode_q), .step_i(step_q), .dir_neg_o(dir_neg),
    .cmd_o(cmd), .sts_i(sts)
  );

  rts_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .band_min_i(band_min_q), .band_max_i(band_max_q), .step_i(step_q),
    .origin_i(origin_q), .mode_i(mode_q), .bfo_i(bfo_q), .dir_neg_i(dir_neg),
    .load_freq_i(load_frequency_khz_i), .load_off_i(load_offset_hz_i),
    .freq_o(frequency_khz_o), .off_o(offset_hz_o), .changed_o
  );

endmodule

// ===== hw/rtl/rts_datapath.sv =====
// Datapath of the tuning stepper: state registers, step arithmetic and a
// bit-serial remainder unit for the channel grid. Depends on rts_pkg.
module rts_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rts_pkg::rts_cmd_t          cmd_i,
  output rts_pkg::rts_sts_t          sts_o,
  input  logic [rts_pkg::FreqW-1:0]  band_min_i,
  input  logic [rts_pkg::FreqW-1:0]  band_max_i,
  input  logic [rts_pkg::StepW-1:0]  step_i,
  input  logic [rts_pkg::FreqW-1:0]  origin_i,
  input  logic [1:0]                 mode_i,
  input  logic [rts_pkg::BfoW-1:0]   bfo_i,
  input  logic                       dir_neg_i,
  input  logic [rts_pkg::FreqW-1:0]  load_freq_i,
  input  logic [rts_pkg::OffW-1:0]   load_off_i,
  output logic [rts_pkg::FreqW-1:0]  freq_o,
  output logic [rts_pkg::OffW-1:0]   off_o,
  output logic                       changed_o
);
  import rts_pkg::*;

  localparam int unsigned DW = FreqW + 2;  // signed working width
  localparam int unsigned RemCntW = $clog2(DW + 1);

  logic [FreqW-1:0] freq_q, freq_d, old_freq_q;
  logic [OffW-1:0]  off_q, off_d, old_off_q;
  logic signed [DW-1:0] wlo_q, whi_q;
  // remainder unit
  logic signed [DW-1:0] num_q;       // signed (x - origin)
  logic [DW-1:0] quo_q;               // magnitude shifting out
  logic [DW-1:0] rem_q;               // partial remainder
  logic [RemCntW-1:0] cnt_q;
  logic [StepW-1:0] r_fin;

  // snapshot and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= BandMinRst;
      off_q  <= '0;
    end else begin
      freq_q <= freq_d;
      off_q  <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      old_freq_q <= freq_q;
      old_off_q  <= off_q;
    end
  end

  // wrap helper values
  logic signed [DW-1:0] f_s, lo_s, hi_s, stp_s, org_s;
  assign f_s   = DW'(signed'({2'b00, freq_q}));
  assign lo_s  = DW'(signed'({2'b00, band_min_i}));
  assign hi_s  = DW'(signed'({2'b00, band_max_i}));
  assign stp_s = DW'(signed'({{(DW-StepW){1'b0}}, step_i}));
  assign org_s = DW'(signed'({2'b00, origin_i}));

  // positive remainder (x-origin) mod step, from magnitude remainder
  always_comb begin
    r_fin = rem_q[StepW-1:0];
    if (num_q[DW-1] && rem_q != '0) r_fin = StepW'(stp_s[StepW:0] - rem_q[StepW:0]);
  end

  // sideband arithmetic: up to two kHz carries per step; a sum of exactly
  // +500 stays as is, and a sum of exactly -500 or -1500 turns into +500
  logic signed [OffW+1:0] o_sum;
  logic signed [DW-1:0] f_sb;
  logic signed [OffW+1:0] o_new;
  always_comb begin
    o_sum = (OffW+2)'(signed'(off_q)) + (dir_neg_i ? -(OffW+2)'(signed'({1'b0, bfo_i}))
                                                  :  (OffW+2)'(signed'({1'b0, bfo_i})));
    f_sb = f_s;
    o_new = o_sum;
    if (o_sum >= 12'sd1501) begin
      o_new = o_sum - 12'sd2000; f_sb = f_s + DW'(2);
    end else if (o_sum >= 12'sd501) begin
      o_new = o_sum - 12'sd1000; f_sb = f_s + DW'(1);
    end else if (o_sum <= -12'sd1500) begin
      o_new = o_sum + 12'sd2000; f_sb = f_s - DW'(2);
    end else if (o_sum <= -12'sd500) begin
      o_new = o_sum + 12'sd1000; f_sb = f_s - DW'(1);
    end
  end

  logic signed [DW-1:0] f_pl, f_gr, f_nx, wl, wh;
  logic grid_on;
  assign grid_on = (mode_i == MODE_GRID) && (step_i != '0);
  assign f_pl = dir_neg_i ? f_s - stp_s : f_s + stp_s;
  always_comb begin
    if (r_fin == '0) f_gr = f_pl;
    else if (dir_neg_i) f_gr = f_s - DW'(signed'({{(DW-StepW){1'b0}}, r_fin}));
    else f_gr = f_s + stp_s - DW'(signed'({{(DW-StepW){1'b0}}, r_fin}));
  end

  // next state
  always_comb begin
    freq_d = freq_q;
    off_d  = off_q;
    f_nx   = f_pl;
    wl     = lo_s;
    wh     = hi_s;
    if (grid_on) begin
      wl = wlo_q; wh = whi_q;
    end
    if (mode_i == MODE_SSB) f_nx = f_sb;
    else if (grid_on) f_nx = f_gr;
    if (cmd_i.load) begin
      freq_d = load_freq_i;
      if ($signed(load_off_i) > 10'sd499) off_d = 10'sd499;
      else if ($signed(load_off_i) < -10'sd499) off_d = -10'sd499;
      else off_d = load_off_i;
    end else if (cmd_i.step || cmd_i.grid_step) begin
      if (f_nx > wh) freq_d = wl[FreqW-1:0];
      else if (f_nx < wl) freq_d = wh[FreqW-1:0];
      else freq_d = f_nx[FreqW-1:0];
      if (mode_i == MODE_SSB) off_d = o_new[OffW-1:0];
    end
  end

  // window for grid wrap: first/last channel inside band
  logic signed [DW-1:0] first_c, last_c;
  always_comb begin
    first_c = (r_fin == '0) ? lo_s : lo_s + stp_s - DW'(signed'({{(DW-StepW){1'b0}}, r_fin}));
    last_c  = hi_s - DW'(signed'({{(DW-StepW){1'b0}}, r_fin}));
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      wlo_q <= lo_s;
      whi_q <= hi_s;
    end else if (cmd_i.edge_lo) begin
      if (hi_s >= lo_s && first_c <= hi_s) wlo_q <= first_c;
    end else if (cmd_i.edge_hi) begin
      if (hi_s >= lo_s && last_c >= lo_s) whi_q <= last_c;
    end
  end

  // bit-serial restoring remainder of |x - origin| by step
  logic signed [DW-1:0] x_sel, n_new;
  logic [DW-1:0] trial;
  assign x_sel = cmd_i.rem_cur ? f_s : (cmd_i.rem_lo ? lo_s : hi_s);
  assign n_new = x_sel - org_s;
  assign trial = {rem_q[DW-2:0], quo_q[DW-1]};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.rem_init) begin
      cnt_q <= RemCntW'(DW);
    end else if (cmd_i.rem_step && cnt_q != '0) begin
      cnt_q <= cnt_q - RemCntW'(1);
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.rem_init) begin
      num_q <= n_new;
      quo_q <= n_new[DW-1] ? DW'(-n_new) : n_new;
      rem_q <= '0;
    end else if (cmd_i.rem_step && cnt_q != '0) begin
      quo_q <= {quo_q[DW-2:0], 1'b0};
      rem_q <= (trial >= DW'(step_i)) ? trial - DW'(step_i) : trial;
    end
  end

  assign sts_o.rem_done = (cnt_q == '0);
  assign freq_o    = freq_q;
  assign off_o     = off_q;
  assign changed_o = (freq_q != old_freq_q) || (off_q != old_off_q);

endmodule

// ===== hw/rtl/rts_ctrl.sv =====
// Controller of the tuning stepper: sequences load, grid edge search and
// the repeat loop, and owns the handshakes. Depends on rts_pkg.
module rts_ctrl #(
  parameter int unsigned MaxRepeats = rts_pkg::MaxRepeatsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  logic                     req_type_i,
  input  logic [1:0]               direction_i,
  input  logic [rts_pkg::RepW-1:0] repeats_i,
  input  logic [1:0]               mode_i,
  input  logic [rts_pkg::StepW-1:0] step_i,
  output logic                     dir_neg_o,
  output rts_pkg::rts_cmd_t        cmd_o,
  input  rts_pkg::rts_sts_t        sts_i
);
  import rts_pkg::*;

  localparam int unsigned CntW = $clog2(MaxRepeats + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LO    = 8'b0000_0010,
    S_LOW   = 8'b0000_0100,
    S_HI    = 8'b0000_1000,
    S_HIW   = 8'b0001_0000,
    S_LOOP  = 8'b0010_0000,
    S_GREM  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic dir_neg_q, dir_neg_d;
  logic grid_on;
  logic [RepW-1:0] reps_sat;

  assign grid_on  = (mode_i == MODE_GRID) && (step_i != '0);
  assign reps_sat = (repeats_i > RepW'(MaxRepeats)) ? RepW'(MaxRepeats) : repeats_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign dir_neg_o   = dir_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      dir_neg_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      dir_neg_q <= dir_neg_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    dir_neg_d = dir_neg_q;
    cmd_o     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          dir_neg_d   = direction_i[1];
          cnt_d       = CntW'(reps_sat);
          if (req_type_i) begin
            cmd_o.load = 1'b1;
            state_d    = S_OUT;
          end else if (direction_i == 2'b00 || repeats_i == '0) begin
            state_d = S_OUT;
          end else if (grid_on) begin
            state_d = S_LO;
          end else begin
            state_d = S_LOOP;
          end
        end
      end
      S_LO: begin
        cmd_o.rem_init = 1'b1; cmd_o.rem_lo = 1'b1; state_d = S_LOW;
      end
      S_LOW: begin
        cmd_o.rem_step = 1'b1;
        if (sts_i.rem_done) begin cmd_o.edge_lo = 1'b1; state_d = S_HI; end
      end
      S_HI: begin
        cmd_o.rem_init = 1'b1; state_d = S_HIW;
      end
      S_HIW: begin
        cmd_o.rem_step = 1'b1;
        if (sts_i.rem_done) begin cmd_o.edge_hi = 1'b1; state_d = S_LOOP; end
      end
      S_LOOP: begin
        if (grid_on) begin
          cmd_o.rem_init = 1'b1; cmd_o.rem_cur = 1'b1; state_d = S_GREM;
        end else begin
          cmd_o.step = 1'b1;
          cnt_d = cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) state_d = S_OUT;
        end
      end
      S_GREM: begin
        cmd_o.rem_step = 1'b1;
        if (sts_i.rem_done) begin
          cmd_o.grid_step = 1'b1;
          cnt_d = cnt_q - CntW'(1);
          state_d = (cnt_q == CntW'(1)) ? S_OUT : S_LOOP;
        end
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/rts_checker.sv =====
// Port-level checker for the tuning stepper, bound to the top level.
// Depends on rts_pkg for widths only.
module rts_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [rts_pkg::FreqW-1:0] frequency_khz_o,
  input logic [rts_pkg::OffW-1:0]  offset_hz_o,
  input logic                      changed_o
);
  import rts_pkg::*;

  // one request at a time: never ready while a result is pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready with result pending");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frequency_khz_o)
      && $stable(offset_hz_o) && $stable(changed_o)) else $error("result moved");

  // state only moves while a request is in flight
  a_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && !in_valid_i |=> $stable(frequency_khz_o) && $stable(offset_hz_o))
    else $error("state moved while idle");

  // offset stays within its range (+500 is reachable on an exact half-kHz sum)
  a_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(offset_hz_o) <= 10'sd500 && $signed(offset_hz_o) >= -10'sd499))
    else $error("offset out of range");

endmodule

bind radio_tuning_stepper rts_checker u_rts_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .frequency_khz_o, .offset_hz_o, .changed_o
);

// ===== bench/tb_radio_tuning_stepper.sv =====
// Self-checking bench for radio_tuning_stepper: directed and random tuning
// requests under several register settings, checked against a local model.
// Depends on rts_pkg and the radio_tuning_stepper RTL.
`timescale 1ns / 100ps

module tb_radio_tuning_stepper;
  import rts_pkg::*;

  localparam bit       REQ_STEP  = 1'b0;
  localparam bit       REQ_LOAD  = 1'b1;
  localparam bit [1:0] DIR_NONE  = 2'b00;
  localparam bit [1:0] DIR_UP    = 2'b01;
  localparam bit [1:0] DIR_DOWN2 = 2'b10;
  localparam bit [1:0] DIR_DOWN  = 2'b11;
  localparam int       WDOG_LIMIT = 20000;

  typedef struct {
    bit        kind;
    bit [1:0]  dir;
    bit [7:0]  reps;
    bit [15:0] freq;
    bit [9:0]  offs;
  } tune_req_t;

  typedef struct {
    bit [15:0] freq;
    bit [9:0]  offs;
    bit        changed;
  } tune_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = 1'b0;
  logic [1:0] direction = '0;
  logic [RepW-1:0] repeats = '0;
  logic [FreqW-1:0] load_freq = '0;
  logic [OffW-1:0] load_offs = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [FreqW-1:0] freq_o;
  logic [OffW-1:0] offs_o;
  logic changed_o;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // model of the tuning state and registers
  int band_lo, band_hi, step_khz, grid_org, bfo_hz;
  tune_mode_e mode;
  int tuned_khz, fine_hz;

  tune_res_t expected_tuning[$];
  int errors, requests_sent, results_seen, phases_run;
  bit tx_idle, rx_idle;
  int stall_left, quiet_cycles;

  always #1 clk_i = ~clk_i;

  radio_tuning_stepper u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .req_type_i          (req_type),
    .direction_i         (direction),
    .repeats_i           (repeats),
    .load_frequency_khz_i(load_freq),
    .load_offset_hz_i    (load_offs),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .frequency_khz_o     (freq_o),
    .offset_hz_o         (offs_o),
    .changed_o           (changed_o),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_data_i          (cfg_data)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic int grid_snap(int f, int org, int spacing, bit up);
    int rem;
    rem = (f - org) % spacing;
    if (rem < 0) rem += spacing;
    if (rem == 0) return f;
    return up ? f + (spacing - rem) : f - rem;
  endfunction

  function automatic int wrap_band(int f, int lo, int hi);
    if (f > hi) return lo;
    if (f < lo) return hi;
    return f;
  endfunction

  // advance the tuning state by one request and return the expected result
  function automatic tune_res_t predict_tuning(tune_req_t q);
    int old_f, old_o, f, o, dir, reps, wlo, whi, first, last, s;
    tune_res_t r;
    old_f = tuned_khz;
    old_o = fine_hz;
    if (q.kind == REQ_LOAD) begin
      o = $signed(q.offs);
      if (o > 499) o = 499;
      if (o < -499) o = -499;
      tuned_khz = q.freq;
      fine_hz = o;
    end else begin
      dir = (q.dir == DIR_NONE) ? 0 : (q.dir[1] ? -1 : 1);
      reps = (q.reps > MaxRepeatsDef) ? MaxRepeatsDef : q.reps;
      if (dir != 0 && reps != 0) begin
        f = tuned_khz;
        if (mode == MODE_SSB) begin
          o = fine_hz;
          for (int k = 0; k < reps; k++) begin
            o += dir * bfo_hz;
            while (o >= 500) begin f++; o -= 1000; end
            while (o <= -500) begin f--; o += 1000; end
            f = wrap_band(f, band_lo, band_hi);
          end
          fine_hz = o;
        end else if (mode == MODE_GRID && step_khz > 0) begin
          wlo = band_lo;
          whi = band_hi;
          if (band_hi >= band_lo) begin
            first = grid_snap(band_lo, grid_org, step_khz, 1'b1);
            last = grid_snap(band_hi, grid_org, step_khz, 1'b0);
            if (first >= band_lo && first <= band_hi) wlo = first;
            if (last >= band_lo && last <= band_hi) whi = last;
          end
          for (int k = 0; k < reps; k++) begin
            s = grid_snap(f, grid_org, step_khz, dir > 0);
            f = (s == f) ? f + step_khz * dir : s;
            f = wrap_band(f, wlo, whi);
          end
        end else begin
          for (int k = 0; k < reps; k++) begin
            f += step_khz * dir;
            f = wrap_band(f, band_lo, band_hi);
          end
        end
        tuned_khz = f & 16'hFFFF;
      end
    end
    r.freq = tuned_khz[15:0];
    r.offs = fine_hz[9:0];
    r.changed = (tuned_khz != old_f || fine_hz != old_o);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got, want);
  endtask

  // result checker, receiver stalls and watchdog
  always @(posedge clk_i) begin
    tune_res_t e;
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WDOG_LIMIT);
      $display("radio_tuning_stepper test failed");
      $finish;
    end
    if (rst_ni && out_valid && out_ready) begin
      if (expected_tuning.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = expected_tuning.pop_front();
        if (freq_o !== e.freq) report_mismatch("frequency_khz", freq_o, e.freq);
        if (offs_o !== e.offs) report_mismatch("offset_hz", $signed(offs_o), $signed(e.offs));
        if (changed_o !== e.changed) report_mismatch("changed", changed_o, e.changed);
      end
      results_seen++;
    end
    if (!rx_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_ready <= 1'b1;
    end
  end

  // send one request and wait for it to be taken
  task automatic send_request(tune_req_t q);
    int gap;
    in_valid <= 1'b1;
    req_type <= q.kind;
    direction <= q.dir;
    repeats <= q.reps;
    load_freq <= q.freq;
    load_offs <= q.offs;
    do @(posedge clk_i); while (!in_ready);
    expected_tuning.push_back(predict_tuning(q));
    requests_sent++;
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_tuning.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic step_req(bit [1:0] dir, bit [7:0] reps);
    tune_req_t q;
    q = '{REQ_STEP, dir, reps, 16'($urandom), 10'($urandom)};
    send_request(q);
  endtask

  task automatic load_req(bit [15:0] f, bit [9:0] o);
    tune_req_t q;
    q = '{REQ_LOAD, 2'($urandom), 8'($urandom), f, o};
    send_request(q);
  endtask

  // write all registers; block must be idle
  task automatic apply_settings(int lo, int hi, int stp, int org, tune_mode_e md, int bfo);
    int vals[6];
    vals = '{lo, hi, stp, org, int'(md), bfo};
    wait_drained();
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= CfgIdxW'(i);
      cfg_data <= CfgDataW'(vals[i]);
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    band_lo = lo & 16'hFFFF;
    band_hi = hi & 16'hFFFF;
    step_khz = stp & 8'hFF;
    grid_org = org & 16'hFFFF;
    mode = tune_mode_e'(md);
    bfo_hz = bfo & 10'h3FF;
    phases_run++;
  endtask

  function automatic tune_req_t random_request();
    tune_req_t q;
    int r;
    q.kind = ($urandom_range(0, 99) < 15) ? REQ_LOAD : REQ_STEP;
    r = $urandom_range(0, 99);
    q.dir = (r < 45) ? DIR_UP : (r < 85) ? DIR_DOWN : (r < 95) ? DIR_DOWN2 : DIR_NONE;
    r = $urandom_range(0, 99);
    if (r < 70) q.reps = $urandom_range(1, 6);
    else if (r < 90) q.reps = $urandom_range(7, 40);
    else if (r < 96) q.reps = 0;
    else q.reps = $urandom_range(41, 255);
    if ($urandom_range(0, 9) < 7 && band_hi >= band_lo)
      q.freq = 16'($urandom_range(band_lo, band_hi));
    else
      q.freq = 16'($urandom);
    q.offs = 10'($urandom);
    return q;
  endfunction

  task automatic test_defaults();
    // reset state, then plain stepping over the default band edges
    step_req(DIR_DOWN, 1);
    step_req(DIR_UP, 1);
    step_req(DIR_NONE, 5);
    step_req(DIR_UP, 0);
    step_req(DIR_DOWN2, 3);
    step_req(DIR_UP, 255);
    load_req(16'd1710, 10'd0);
    step_req(DIR_UP, 1);
    load_req(16'hFFFF, 10'h1FF);
    load_req(16'h0000, 10'h200);
    load_req(16'd1000, 10'($signed(-499)));
    step_req(DIR_UP, 1);
  endtask

  task automatic test_modes();
    apply_settings(520, 1710, 9, 1, MODE_GRID, 10);
    load_req(16'd1004, 10'd0);
    step_req(DIR_UP, 1);
    step_req(DIR_DOWN, 2);
    step_req(DIR_UP, 128);
    apply_settings(520, 1710, 0, 0, MODE_GRID, 10);
    load_req(16'd3000, 10'd0);
    step_req(DIR_UP, 1);
    apply_settings(520, 1710, 10, 0, MODE_SSB, 1000);
    load_req(16'd520, 10'd499);
    step_req(DIR_DOWN, 4);
    step_req(DIR_UP, 3);
    apply_settings(1710, 520, 10, 0, MODE_SPARE, 0);
    step_req(DIR_UP, 2);
    step_req(DIR_DOWN, 2);
  endtask

  task automatic test_random_phases();
    int lo, hi, stp;
    for (int p = 0; p < 12; p++) begin
      tx_idle = (p % 4) != 3;
      rx_idle = (p % 3) != 2;
      case (p)
        0: apply_settings(0, 65535, 255, 65535, MODE_GRID, 1000);
        1: apply_settings(0, 65535, 1, 0, MODE_SSB, 1);
        2: apply_settings(65535, 0, 0, 0, MODE_PLAIN, 1023);
        3: apply_settings(100, 100, 7, 3, MODE_GRID, 0);
        default: begin
          lo = $urandom_range(0, 3000);
          hi = ($urandom_range(0, 9) == 0) ? lo - $urandom_range(1, 50)
                                           : lo + $urandom_range(0, 400);
          stp = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255);
          apply_settings(lo, hi, stp, $urandom, tune_mode_e'($urandom_range(0, 3)),
                         ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 1000));
        end
      endcase
      for (int i = 0; i < 155; i++) send_request(random_request());
    end
  endtask

  task automatic test_drain_pauses();
    // sender holds off until every result is back after every fifth request
    apply_settings(520, 1710, 10, 5, MODE_GRID, 10);
    tx_idle = 1;
    rx_idle = 1;
    for (int i = 0; i < 30; i++) begin
      send_request(random_request());
      if (i % 5 == 4) wait_drained();
    end
  endtask

  initial begin
    band_lo = BandMinRst;
    band_hi = BandMaxRst;
    step_khz = StepRst;
    grid_org = 0;
    mode = MODE_PLAIN;
    bfo_hz = BfoRst;
    tuned_khz = BandMinRst;
    fine_hz = 0;
    tx_idle = 1;
    rx_idle = 1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_modes();
    test_random_phases();
    test_drain_pauses();
    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("covered %0d requests, %0d results, %0d register settings",
             requests_sent, results_seen, phases_run);
    $display("modes plain/grid/sideband/spare, inverted and full bands, %0d mismatches",
             errors);
    if (errors == 0) $display("radio_tuning_stepper test passed");
    else $display("radio_tuning_stepper test failed");
    $finish;
  end

endmodule
